FILE: design/pbp_pkg.sv
// Package for the point box projection filter: request and result structs,
// box and configuration types, action and register codes. No dependencies.
`default_nettype none
package pbp_pkg;

  localparam int SIDE_W  = 14;
  localparam int COORD_W = 12;
  localparam int DIV_N   = 41;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 32;

  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_BOX   = 2'd1;
  localparam logic [1:0] ACT_POINT = 2'd2;

  localparam logic [CFG_A_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_SKEW_X   = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_SKEW_Y   = 3'd5;
  localparam logic [CFG_A_W-1:0] REG_WANTED   = 3'd6;

  typedef struct packed {
    logic [1:0]         action;
    logic [12:0]        frame_width;
    logic [12:0]        frame_height;
    logic [11:0]        corner_x1;
    logic [11:0]        corner_y1;
    logic [11:0]        corner_x2;
    logic [11:0]        corner_y2;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] kept_x;
    logic signed [31:0] kept_y;
    logic signed [31:0] kept_z;
    logic [11:0]        pixel_col;
    logic [11:0]        pixel_row;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } pt_t;

  typedef struct packed {
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] yl;
    logic [COORD_W-1:0] xh;
    logic [COORD_W-1:0] yh;
  } box_t;

  typedef struct packed {
    logic [31:0]        focal_x;
    logic [31:0]        focal_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] skew_x;
    logic signed [31:0] skew_y;
    logic [4:0]         wanted;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic busy;
  } q_ctl_t;

endpackage
`default_nettype wire

FILE: design/pbp_queue.sv
// Two-entry request queue between front and back of the filter.
// Depends on pbp_pkg for the point type.
`default_nettype none
module pbp_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire pbp_pkg::pt_t push_data,
  input  wire logic         pop,
  output pbp_pkg::pt_t      pop_data,
  output logic              full,
  output logic              empty
);
  pbp_pkg::pt_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assign pop_data = mem_r[rp_r];
  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
endmodule
`default_nettype wire

FILE: design/pbp_front.sv
// Front of the filter: accepts requests, keeps frame size and box list,
// forwards points to the queue. Depends on pbp_pkg.
`default_nettype none
module pbp_front #(
  parameter int MAX_BOXES = 16,
  parameter int MAX_SIDE  = 4096,
  localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pbp_pkg::in_item_t             in_data,
  input  wire pbp_pkg::q_ctl_t               qs,
  output logic                               push,
  output pbp_pkg::pt_t                       push_data,
  output pbp_pkg::box_t [MAX_BOXES-1:0]      boxes,
  output logic [CNT_W-1:0]                   box_count,
  output logic [pbp_pkg::SIDE_W-1:0]         cols,
  output logic [pbp_pkg::SIDE_W-1:0]         rows
);
  localparam logic [pbp_pkg::SIDE_W-1:0] SIDE_MAX = pbp_pkg::SIDE_W'(MAX_SIDE);

  pbp_pkg::box_t [MAX_BOXES-1:0] box_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [pbp_pkg::SIDE_W-1:0]    cols_r, rows_r;
  logic                          acc;
  logic [pbp_pkg::SIDE_W-1:0]    w_ext, h_ext;
  pbp_pkg::box_t                 nb;

  always_comb begin
    if (in_data.action == pbp_pkg::ACT_POINT) in_stall = qs.full;
    else in_stall = !(qs.empty && !qs.busy);
  end

  assign acc  = in_valid && !in_stall;
  assign push = acc && in_data.action == pbp_pkg::ACT_POINT;
  assign push_data = '{px: in_data.point_x, py: in_data.point_y, pz: in_data.point_z};

  assign w_ext = pbp_pkg::SIDE_W'(in_data.frame_width);
  assign h_ext = pbp_pkg::SIDE_W'(in_data.frame_height);

  always_comb begin
    nb.xl = (in_data.corner_x1 < in_data.corner_x2) ? in_data.corner_x1 : in_data.corner_x2;
    nb.xh = (in_data.corner_x1 < in_data.corner_x2) ? in_data.corner_x2 : in_data.corner_x1;
    nb.yl = (in_data.corner_y1 < in_data.corner_y2) ? in_data.corner_y1 : in_data.corner_y2;
    nb.yh = (in_data.corner_y1 < in_data.corner_y2) ? in_data.corner_y2 : in_data.corner_y1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cols_r <= '0;
      rows_r <= '0;
    end else if (acc) begin
      if (in_data.action == pbp_pkg::ACT_FRAME) begin
        cols_r <= (w_ext > SIDE_MAX) ? SIDE_MAX : w_ext;
        rows_r <= (h_ext > SIDE_MAX) ? SIDE_MAX : h_ext;
        cnt_r  <= '0;
      end else if (in_data.action == pbp_pkg::ACT_BOX && cnt_r < CNT_W'(MAX_BOXES)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (acc && in_data.action == pbp_pkg::ACT_BOX && cnt_r == CNT_W'(i)) box_r[i] <= nb;
    end
  end

  assign boxes     = box_r;
  assign box_count = cnt_r;
  assign cols      = cols_r;
  assign rows      = rows_r;
endmodule
`default_nettype wire

FILE: design/pbp_back.sv
// Back of the filter: multiply, numerator, pipelined divide, bounds, box
// label and output register. Depends on pbp_pkg.
`default_nettype none
module pbp_back #(
  parameter int MAX_BOXES = 16,
  localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pbp_pkg::cfg_t                 cfg,
  input  wire pbp_pkg::box_t [MAX_BOXES-1:0] boxes,
  input  wire logic [CNT_W-1:0]              box_count,
  input  wire logic [pbp_pkg::SIDE_W-1:0]    cols,
  input  wire logic [pbp_pkg::SIDE_W-1:0]    rows,
  input  wire logic                          q_empty,
  input  wire pbp_pkg::pt_t                  q_data,
  output logic                               pop,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pbp_pkg::out_item_t                 out_result
);
  localparam int N = pbp_pkg::DIV_N;
  localparam int SW = pbp_pkg::SIDE_W;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic void numer(input logic [63:0] mp, input logic sp,
                                input logic signed [31:0] s,
                                output logic [64:0] m, output logic neg);
    logic [64:0] a, b, d;
    logic np, ns;
    np = sp && (mp != 64'd0);
    ns = s[31];
    a  = {1'b0, mp};
    b  = {17'd0, mag32(s), 16'd0};
    d  = a - b;
    if (np == ns) begin
      m = a + b; neg = np;
    end else if (!d[64]) begin
      m = d; neg = np;
    end else begin
      m = b - a; neg = ns;
    end
  endfunction

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;

  // multiply stage
  logic         m_vld_r;
  pbp_pkg::pt_t m_pt_r;
  logic [63:0]  mpx_r, mpy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else if (adv) m_vld_r <= pop && q_data.pz > 0;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_pt_r <= q_data;
      mpx_r  <= cfg.focal_x * mag32(q_data.px);
      mpy_r  <= cfg.focal_y * mag32(q_data.py);
    end
  end

  // numerator stage
  logic         n_vld_r;
  pbp_pkg::pt_t n_pt_r;
  logic [64:0]  nmx_r, nmy_r, nmx_nxt, nmy_nxt;
  logic         nnx_r, nny_r, nnx_nxt, nny_nxt;

  always_comb begin
    numer(mpx_r, m_pt_r.px[31], cfg.skew_x, nmx_nxt, nnx_nxt);
    numer(mpy_r, m_pt_r.py[31], cfg.skew_y, nmy_nxt, nny_nxt);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else if (adv) n_vld_r <= m_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      n_pt_r <= m_pt_r;
      nmx_r  <= nmx_nxt;
      nmy_r  <= nmy_nxt;
      nnx_r  <= nnx_nxt;
      nny_r  <= nny_nxt;
    end
  end

  // divide stages, one quotient bit each
  logic         d_vld_r [N];
  pbp_pkg::pt_t d_pt_r  [N];
  logic [30:0]  d_rx_r  [N];
  logic [30:0]  d_ry_r  [N];
  logic [N-1:0] d_lx_r  [N];
  logic [N-1:0] d_ly_r  [N];
  logic         d_nx_r  [N];
  logic         d_ny_r  [N];
  logic         d_ox_r  [N];
  logic         d_oy_r  [N];

  for (genvar j = 0; j < N; j++) begin : g_div
    logic         vi, nxi, nyi, oxi, oyi;
    pbp_pkg::pt_t pi;
    logic [30:0]  rxi, ryi, z;
    logic [N-1:0] lxi, lyi;
    logic [31:0]  tx, ty;
    logic         gx, gy;

    if (j == 0) begin : g_first
      assign vi  = n_vld_r;
      assign pi  = n_pt_r;
      assign rxi = 31'(nmx_r[64:N]);
      assign ryi = 31'(nmy_r[64:N]);
      assign lxi = nmx_r[N-1:0];
      assign lyi = nmy_r[N-1:0];
      assign nxi = nnx_r;
      assign nyi = nny_r;
      assign oxi = 31'(nmx_r[64:N]) >= n_pt_r.pz[30:0];
      assign oyi = 31'(nmy_r[64:N]) >= n_pt_r.pz[30:0];
    end else begin : g_next
      assign vi  = d_vld_r[j-1];
      assign pi  = d_pt_r[j-1];
      assign rxi = d_rx_r[j-1];
      assign ryi = d_ry_r[j-1];
      assign lxi = d_lx_r[j-1];
      assign lyi = d_ly_r[j-1];
      assign nxi = d_nx_r[j-1];
      assign nyi = d_ny_r[j-1];
      assign oxi = d_ox_r[j-1];
      assign oyi = d_oy_r[j-1];
    end

    assign z  = pi.pz[30:0];
    assign tx = {rxi, lxi[N-1]};
    assign ty = {ryi, lyi[N-1]};
    assign gx = tx >= {1'b0, z};
    assign gy = ty >= {1'b0, z};

    always_ff @(posedge clk) begin
      if (!rst_n) d_vld_r[j] <= 1'b0;
      else if (adv) d_vld_r[j] <= vi;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_pt_r[j] <= pi;
        d_rx_r[j] <= gx ? 31'(tx - {1'b0, z}) : tx[30:0];
        d_ry_r[j] <= gy ? 31'(ty - {1'b0, z}) : ty[30:0];
        d_lx_r[j] <= {lxi[N-2:0], gx};
        d_ly_r[j] <= {lyi[N-2:0], gy};
        d_nx_r[j] <= nxi;
        d_ny_r[j] <= nyi;
        d_ox_r[j] <= oxi;
        d_oy_r[j] <= oyi;
      end
    end
  end

  // bounds stage
  logic signed [42:0] vx, vy;
  logic               inx, iny;
  logic               b_vld_r;
  pbp_pkg::pt_t       b_pt_r;
  logic [SW-1:0]      b_col_r, b_row_r;

  always_comb begin
    logic signed [42:0] qx, qy;
    qx  = $signed({2'b00, d_lx_r[N-1]});
    qy  = $signed({2'b00, d_ly_r[N-1]});
    vx  = (d_nx_r[N-1] ? -qx : qx) + 43'(cfg.center_x);
    vy  = (d_ny_r[N-1] ? -qy : qy) + 43'(cfg.center_y);
    inx = (vx > -43'sd65536) && (vx[42] ? (cols != '0) : (vx[42:16] < 27'(cols)));
    iny = (vy > -43'sd65536) && (vy[42] ? (rows != '0) : (vy[42:16] < 27'(rows)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= d_vld_r[N-1] && !d_ox_r[N-1] && !d_oy_r[N-1] && inx && iny;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_pt_r  <= d_pt_r[N-1];
      b_col_r <= vx[42] ? '0 : vx[16+SW-1:16];
      b_row_r <= vy[42] ? '0 : vy[16+SW-1:16];
    end
  end

  // box hit stage
  logic                 h_vld_r;
  pbp_pkg::pt_t         h_pt_r;
  logic [SW-1:0]        h_col_r, h_row_r;
  logic [MAX_BOXES-1:0] h_hit_r, hit_nxt;

  always_comb begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      hit_nxt[i] = (CNT_W'(i) < box_count)
                && b_col_r >= SW'(boxes[i].xl) && b_col_r <= SW'(boxes[i].xh)
                && b_row_r >= SW'(boxes[i].yl) && b_row_r <= SW'(boxes[i].yh);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else if (adv) h_vld_r <= b_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      h_pt_r  <= b_pt_r;
      h_col_r <= b_col_r;
      h_row_r <= b_row_r;
      h_hit_r <= hit_nxt;
    end
  end

  // label and output register
  logic [7:0]          label;
  logic                o_vld_r;
  pbp_pkg::out_item_t  o_data_r;

  always_comb begin
    label = 8'd0;
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (h_hit_r[i]) label = 8'(i + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else if (adv) o_vld_r <= h_vld_r && label == 8'(cfg.wanted);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      o_data_r.kept_x    <= h_pt_r.px;
      o_data_r.kept_y    <= h_pt_r.py;
      o_data_r.kept_z    <= h_pt_r.pz;
      o_data_r.pixel_col <= h_col_r[11:0];
      o_data_r.pixel_row <= h_row_r[11:0];
    end
  end

  always_comb begin
    busy = m_vld_r || n_vld_r || b_vld_r || h_vld_r || o_vld_r;
    for (int j = 0; j < N; j++) busy = busy || d_vld_r[j];
  end

  assign out_valid  = o_vld_r;
  assign out_result = o_data_r;
endmodule
`default_nettype wire

FILE: design/point_box_projection_filter.sv
// Top level of the point box projection filter: configuration registers,
// front, queue and back. Depends on pbp_pkg, pbp_front, pbp_queue, pbp_back.
//
// Points are projected through a pinhole model and kept when their pixel lies
// inside the image and carries the chosen box label. A point request is taken
// every cycle while the request queue is not full. The back pipeline is the
// 41-stage divider (one quotient bit a stage) plus multiply, numerator, bounds,
// box hit and output stages. Frame and box requests are held until the queue
// and the back pipeline are empty. A result waiting in the output register
// stalls the whole back.
`default_nettype none
module point_box_projection_filter #(
  parameter int MAX_BOXES = 16,
  parameter int MAX_SIDE  = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pbp_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pbp_pkg::out_item_t                 out_result,
  input  wire logic                          cfg_we,
  input  wire logic [pbp_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [pbp_pkg::CFG_D_W-1:0]   cfg_wdata
);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  pbp_pkg::cfg_t                 cfg_r;
  pbp_pkg::q_ctl_t               qs;
  pbp_pkg::pt_t                  push_data, pop_data;
  pbp_pkg::box_t [MAX_BOXES-1:0] boxes;
  logic [CNT_W-1:0]              box_count;
  logic [pbp_pkg::SIDE_W-1:0]    cols, rows;
  logic                          push, pop, full, empty, busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pbp_pkg::REG_FOCAL_X:  cfg_r.focal_x  <= cfg_wdata;
        pbp_pkg::REG_FOCAL_Y:  cfg_r.focal_y  <= cfg_wdata;
        pbp_pkg::REG_CENTER_X: cfg_r.center_x <= cfg_wdata;
        pbp_pkg::REG_CENTER_Y: cfg_r.center_y <= cfg_wdata;
        pbp_pkg::REG_SKEW_X:   cfg_r.skew_x   <= cfg_wdata;
        pbp_pkg::REG_SKEW_Y:   cfg_r.skew_y   <= cfg_wdata;
        pbp_pkg::REG_WANTED:   cfg_r.wanted   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign qs = '{full: full, empty: empty, busy: busy};

  pbp_front #(.MAX_BOXES(MAX_BOXES), .MAX_SIDE(MAX_SIDE)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .qs,
    .push, .push_data, .boxes, .box_count, .cols, .rows
  );

  pbp_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data, .full, .empty
  );

  pbp_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .boxes, .box_count, .cols, .rows,
    .q_empty(empty), .q_data(pop_data), .pop, .busy,
    .out_valid, .out_stall, .out_result
  );

`ifndef SYNTHESIS
  a_ctl_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.action != pbp_pkg::ACT_POINT) |-> (empty && !busy))
    else $error("frame or box request taken while points in flight");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("request queue overflow");

  a_depth_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.kept_z > 0))
    else $error("result with nonpositive depth");

  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.action == pbp_pkg::ACT_FRAME) |=> (box_count == '0))
    else $error("box list not cleared by frame request");
`endif
endmodule
`default_nettype wire
